// ===== hdl/mmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI message framer package
// Shared widths, codes, result type, pointer helper and data byte count helper.
// ----------------------------------------------------------------------------
package mmf_pkg;

    localparam int ADDR_BITS  = 13;
    localparam int END_BITS   = ADDR_BITS + 1;
    localparam int BYTE_BITS  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = END_BITS;
    localparam int TDATA_W    = 56;
    localparam int TUSER_W    = 2;
    localparam int QUEUE_DEPTH = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_END   = 2'd1;

    localparam logic [ADDR_BITS-1:0] RING_START_RST = ADDR_BITS'(32);
    localparam logic [END_BITS-1:0]  RING_END_RST   = END_BITS'(4084);

    localparam logic [7:0] SYSEX_START  = 8'hf0;
    localparam logic [7:0] SYSEX_END    = 8'hf7;
    localparam logic [7:0] SONG_POS     = 8'hf2;
    localparam logic [7:0] MTC_QUARTER  = 8'hf1;
    localparam logic [7:0] SONG_SELECT  = 8'hf3;
    localparam logic [7:0] SYSEX_LEAD   = 8'h7d;
    localparam logic [7:0] IRQ_COUNT    = 8'h84;
    localparam logic [7:0] LEAD_COUNT   = 8'h80;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_MSG   = 3'b010,
        MODE_SYSEX = 3'b100
    } mode_t;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic [ADDR_BITS-1:0] out_addr;
        logic                 last;
        logic                 msg_done;
        logic [ADDR_BITS-1:0] write_index;
        logic                 irq_valid;
        logic [7:0]           irq_code;
        logic [7:0]           sysex_errors;
    } res_t;

    function automatic logic [ADDR_BITS-1:0] next_ptr(
        input logic [ADDR_BITS-1:0] addr,
        input logic [ADDR_BITS-1:0] ring_start,
        input logic [END_BITS-1:0]  ring_end
    );
        logic [END_BITS-1:0] inc;
        inc = {1'b0, addr} + END_BITS'(1);
        if (inc >= ring_end)
        begin
            return ring_start;
        end
        return inc[ADDR_BITS-1:0];
    endfunction

    function automatic logic [1:0] data_count(input logic [7:0] b);
        logic [1:0] cnt;
        cnt = 2'd0;
        case (b[7:4])
            4'h8, 4'h9, 4'ha, 4'hb, 4'he: cnt = 2'd2;
            4'hc, 4'hd:                   cnt = 2'd1;
            4'hf:
            begin
                if (b == SONG_POS)
                begin
                    cnt = 2'd2;
                end
                else if (b == MTC_QUARTER || b == SONG_SELECT)
                begin
                    cnt = 2'd1;
                end
            end
            default: cnt = 2'd0;
        endcase
        return cnt;
    endfunction

endpackage

// ===== hdl/midi_message_framer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI message framer core
// Frames received MIDI bytes into whole messages with ring buffer addresses.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// s_*     | in        | tdata[7:0] rx_byte
// m_*     | out       | tdata: stored byte, addresses, interrupt code, error count;
//         |           | tuser: msg_done, irq_valid; tlast: last result of the byte
// cfg_*   | in        | cfg_index selects ring_start or ring_end, cfg_data the value
//
// A byte is parsed in the cycle of its transfer and its results enter a
// three-entry result queue; the queue head drives the m_* channel.
// One result leaves per cycle while m_tready is high; a byte gives one result,
// none when it is dropped, or two when a running status byte is reinserted ahead of it.
// Input is taken while the queue holds at most one result, so a stalled
// output side holds back the input. Reset empties the queue and clears parser state.
// ----------------------------------------------------------------------------
module midi_message_framer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] out_byte, [20:8] out_addr, [33:21] write_index,
    // [41:34] irq_code, [49:42] sysex_errors, [55:50] zero
    output logic [mmf_pkg::TDATA_W-1:0]         m_tdata,
    output logic [mmf_pkg::TUSER_W-1:0]         m_tuser,   // [0] msg_done, [1] irq_valid
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mmf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mmf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import mmf_pkg::*;

    logic [ADDR_BITS-1:0] ring_start_reg;
    logic [END_BITS-1:0]  ring_end_reg;
    mode_t                mode_reg, mode_next;
    logic [1:0]           data_left_reg, data_left_next;
    logic [7:0]           running_reg, running_next;
    logic [7:0]           sysex_cnt_reg, sysex_cnt_next;
    logic [ADDR_BITS-1:0] wptr_reg, wptr_next;
    logic [7:0]           err_cnt_reg, err_cnt_next;
    res_t                 queue_reg [QUEUE_DEPTH];
    res_t                 queue_next [QUEUE_DEPTH];
    logic [1:0]           count_reg, count_next;

    logic                 in_xfer;
    logic                 out_xfer;
    logic [1:0]           n_res;
    res_t                 res0, res1;
    logic [1:0]           base;
    logic [ADDR_BITS-1:0] ptr1, ptr2;
    logic [7:0]           b;
    logic [7:0]           cnt_inc;
    logic                 done;
    logic                 irq;
    logic [1:0]           cnt;
    res_t                 shifted [QUEUE_DEPTH];

    assign cfg_ready = 1'b1;
    assign s_tready  = (count_reg < 2'd2);
    assign m_tvalid  = (count_reg != 2'd0);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = m_tvalid && m_tready;
    assign b         = s_tdata;
    assign ptr1      = next_ptr(wptr_reg, ring_start_reg, ring_end_reg);
    assign ptr2      = next_ptr(ptr1, ring_start_reg, ring_end_reg);

    assign m_tdata = {6'd0, queue_reg[0].sysex_errors, queue_reg[0].irq_code,
                      queue_reg[0].write_index, queue_reg[0].out_addr,
                      queue_reg[0].out_byte};
    assign m_tuser = {queue_reg[0].irq_valid, queue_reg[0].msg_done};
    assign m_tlast = queue_reg[0].last;

    always_comb
    begin
        mode_next      = mode_reg;
        data_left_next = data_left_reg;
        running_next   = running_reg;
        sysex_cnt_next = sysex_cnt_reg;
        err_cnt_next   = err_cnt_reg;
        n_res          = 2'd0;
        cnt_inc        = sysex_cnt_reg + 8'd1;
        done           = 1'b0;
        irq            = 1'b0;
        cnt            = data_count(b);

        res0              = '0;
        res0.out_byte     = b;
        res0.out_addr     = wptr_reg;
        res0.write_index  = ptr1;
        res0.last         = 1'b1;
        res0.sysex_errors = err_cnt_reg;
        res1              = '0;
        res1.out_byte     = b;
        res1.out_addr     = ptr1;
        res1.write_index  = ptr2;
        res1.last         = 1'b1;
        res1.sysex_errors = err_cnt_reg;

        case (mode_reg)
            MODE_SYSEX:
            begin
                sysex_cnt_next = (b == SYSEX_LEAD && cnt_inc == 8'd1) ? LEAD_COUNT : cnt_inc;
                irq  = (sysex_cnt_next == IRQ_COUNT);
                done = b[7];
                if (b[7] && b != SYSEX_END)
                begin
                    err_cnt_next = err_cnt_reg + 8'd1;
                end
                if (done)
                begin
                    mode_next = MODE_IDLE;
                end
                n_res             = 2'd1;
                res0.msg_done     = done;
                res0.irq_valid    = irq;
                res0.irq_code     = irq ? b : 8'd0;
                res0.sysex_errors = err_cnt_next;
            end
            MODE_MSG:
            begin
                done           = (data_left_reg <= 2'd1);
                data_left_next = done ? 2'd0 : data_left_reg - 2'd1;
                if (done)
                begin
                    mode_next = MODE_IDLE;
                end
                n_res         = 2'd1;
                res0.msg_done = done;
            end
            default:
            begin
                if (b[7])
                begin
                    if (b[7:4] inside {4'h9, 4'hb, 4'he})
                    begin
                        running_next = b;
                    end
                    if (b[7:4] == 4'hf && b[3] == 1'b0)
                    begin
                        running_next = 8'd0;
                    end
                    n_res = 2'd1;
                    if (cnt != 2'd0)
                    begin
                        mode_next      = MODE_MSG;
                        data_left_next = cnt;
                    end
                    else if (b == SYSEX_START)
                    begin
                        mode_next      = MODE_SYSEX;
                        sysex_cnt_next = 8'd0;
                    end
                    else
                    begin
                        mode_next     = MODE_IDLE;
                        res0.msg_done = 1'b1;
                    end
                end
                else if (running_reg != 8'd0)
                begin
                    n_res          = 2'd2;
                    res0.out_byte  = running_reg;
                    res0.last      = 1'b0;
                    mode_next      = MODE_MSG;
                    data_left_next = 2'd1;
                end
                else
                begin
                    mode_next = mode_reg;
                end
            end
        endcase
    end

    always_comb
    begin
        base       = count_reg - {1'b0, out_xfer};
        count_next = base + (in_xfer ? n_res : 2'd0);
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (out_xfer && i < QUEUE_DEPTH - 1)
            begin
                shifted[i] = queue_reg[i + 1];
            end
            else
            begin
                shifted[i] = queue_reg[i];
            end
            queue_next[i] = shifted[i];
            if (in_xfer && n_res != 2'd0 && 2'(i) == base)
            begin
                queue_next[i] = res0;
            end
            if (in_xfer && n_res == 2'd2 && 2'(i) == base + 2'd1)
            begin
                queue_next[i] = res1;
            end
        end
        if (!in_xfer)
        begin
            wptr_next = wptr_reg;
        end
        else if (n_res == 2'd2)
        begin
            wptr_next = ptr2;
        end
        else if (n_res == 2'd1)
        begin
            wptr_next = ptr1;
        end
        else
        begin
            wptr_next = wptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_start_reg <= RING_START_RST;
            ring_end_reg   <= RING_END_RST;
            mode_reg       <= MODE_IDLE;
            data_left_reg  <= 2'd0;
            running_reg    <= 8'd0;
            sysex_cnt_reg  <= 8'd0;
            wptr_reg       <= RING_START_RST;
            err_cnt_reg    <= 8'd0;
            count_reg      <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RING_START: ring_start_reg <= cfg_data[ADDR_BITS-1:0];
                    CFG_RING_END:   ring_end_reg   <= cfg_data;
                    default:        ring_end_reg   <= ring_end_reg;
                endcase
            end
            if (in_xfer)
            begin
                mode_reg      <= mode_next;
                data_left_reg <= data_left_next;
                running_reg   <= running_next;
                sysex_cnt_reg <= sysex_cnt_next;
                err_cnt_reg   <= err_cnt_next;
            end
            wptr_reg  <= wptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            queue_reg[i] <= queue_next[i];
        end
    end

endmodule

// ===== hdl/mmf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI message framer port checker
// Watches the top-level ports for output stalls, reset, input acceptance, interrupt codes and last marking.
// ----------------------------------------------------------------------------
module mmf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mmf_pkg::TDATA_W-1:0]    m_tdata,
    input logic [mmf_pkg::TUSER_W-1:0]    m_tuser,
    input logic                           m_tlast
);
    import mmf_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transfer changed while stalled");

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result offered during reset");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input refused with empty result queue");

    a_irq_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata[41:34] == 8'd0)
        else $error("interrupt code set without interrupt");

    a_irq_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1] || m_tuser[0]) |-> m_tlast)
        else $error("completing result not marked last");

endmodule

bind midi_message_framer_core mmf_checker u_mmf_checker (.*);

// ===== tb/sv/midi_message_framer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI message framer core testbench
// Feeds directed and random MIDI byte streams through the input channel. The
// ring settings change between phases, and both the input and the output
// channel idle and stall at random. Each output transfer is checked field by
// field against a framer model that is kept in the testbench.
// ----------------------------------------------------------------------------
module midi_message_framer_core_tb;

    import mmf_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 600000;
    localparam int CHUNK_ITEMS = 200;
    localparam int RANDOM_GOAL = 1300;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [TUSER_W-1:0]    m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Framer model state
    mode_t                 parse_mode   = MODE_IDLE;
    logic [1:0]            bytes_owed   = 2'd0;
    logic [7:0]            run_status   = 8'h00;
    logic [7:0]            sx_count     = 8'h00;
    logic [7:0]            sx_errors    = 8'h00;
    logic [ADDR_BITS-1:0]  wr_ptr       = RING_START_RST;
    logic [ADDR_BITS-1:0]  ring_start_r = RING_START_RST;
    logic [END_BITS-1:0]   ring_end_r   = RING_END_RST;

    res_t                  stores_due[$];
    logic [7:0]            rx_pending[$];
    int unsigned           framed_bytes = 0;
    int unsigned           mismatches   = 0;
    int unsigned           cycles       = 0;
    bit                    quiet_phase  = 1'b0;
    int unsigned           src_wait     = 0;
    int unsigned           sink_wait    = 0;

    midi_message_framer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic int unsigned draw_gap();
        int unsigned r;
        if (quiet_phase)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [1:0] status_length(input logic [7:0] b);
        if (b[7:4] == 4'hc || b[7:4] == 4'hd || b == MTC_QUARTER || b == SONG_SELECT)
        begin
            return 2'd1;
        end
        if ((b[7:4] >= 4'h8 && b[7:4] <= 4'hb) || b[7:4] == 4'he || b == SONG_POS)
        begin
            return 2'd2;
        end
        return 2'd0;
    endfunction

    // Stores one byte at the write pointer and advances it round the ring.
    function automatic res_t ring_store(input logic [7:0] b, input logic done,
                                        input logic irq);
        res_t                r;
        logic [END_BITS-1:0] bumped;
        r          = '0;
        r.out_byte = b;
        r.out_addr = wr_ptr;
        bumped     = {1'b0, wr_ptr} + 1'b1;
        if (bumped >= ring_end_r)
        begin
            wr_ptr = ring_start_r;
        end
        else
        begin
            wr_ptr = bumped[ADDR_BITS-1:0];
        end
        r.msg_done     = done;
        r.write_index  = wr_ptr;
        r.irq_valid    = irq;
        r.irq_code     = irq ? b : 8'h00;
        r.sysex_errors = sx_errors;
        return r;
    endfunction

    task automatic frame_byte(input logic [7:0] b);
        res_t got [2];
        res_t r;
        int   n;
        logic done;
        logic irq;
        n = 0;
        if (parse_mode == MODE_SYSEX)
        begin
            sx_count = sx_count + 8'd1;
            if (b == SYSEX_LEAD && sx_count == 8'd1)
            begin
                sx_count = LEAD_COUNT;
            end
            irq  = (sx_count == IRQ_COUNT);
            done = 1'b0;
            if (b == SYSEX_END)
            begin
                done = 1'b1;
            end
            else if (b[7])
            begin
                sx_errors = sx_errors + 8'd1;
                done      = 1'b1;
            end
            if (done)
            begin
                parse_mode = MODE_IDLE;
            end
            got[n] = ring_store(b, done, irq);
            n = n + 1;
        end
        else if (parse_mode == MODE_MSG)
        begin
            done       = (bytes_owed <= 2'd1);
            bytes_owed = done ? 2'd0 : bytes_owed - 2'd1;
            if (done)
            begin
                parse_mode = MODE_IDLE;
            end
            got[n] = ring_store(b, done, 1'b0);
            n = n + 1;
        end
        else if (b[7])
        begin
            if (b[7:4] == 4'h9 || b[7:4] == 4'hb || b[7:4] == 4'he)
            begin
                run_status = b;
            end
            if (b[7:4] == 4'hf && !b[3])
            begin
                run_status = 8'h00;
            end
            if (status_length(b) != 2'd0)
            begin
                parse_mode = MODE_MSG;
                bytes_owed = status_length(b);
                got[n] = ring_store(b, 1'b0, 1'b0);
            end
            else if (b == SYSEX_START)
            begin
                parse_mode = MODE_SYSEX;
                sx_count   = 8'h00;
                got[n] = ring_store(b, 1'b0, 1'b0);
            end
            else
            begin
                parse_mode = MODE_IDLE;
                got[n] = ring_store(b, 1'b1, 1'b0);
            end
            n = n + 1;
        end
        else if (run_status != 8'h00)
        begin
            got[0] = ring_store(run_status, 1'b0, 1'b0);
            got[1] = ring_store(b, 1'b0, 1'b0);
            n = 2;
            parse_mode = MODE_MSG;
            bytes_owed = 2'd1;
        end
        for (int i = 0; i < n; i++)
        begin
            r      = got[i];
            r.last = (i == n - 1);
            stores_due.push_back(r);
        end
        if (n > 0)
        begin
            framed_bytes++;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
            mismatches++;
        end
    endtask

    // Input side: holds each byte until its transfer, then waits a random gap.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (src_wait != 0)
            begin
                s_tvalid <= 1'b0;
                src_wait <= src_wait - 1;
            end
            else if (rx_pending.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= rx_pending.pop_front();
                src_wait <= draw_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: after a transfer the receiver may stall for a while.
    always @(posedge clk)
    begin : sink_ctrl
        int unsigned pause;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            pause = draw_gap();
            if (pause != 0)
            begin
                m_tready  <= 1'b0;
                sink_wait <= pause - 1;
            end
        end
        else if (sink_wait != 0)
        begin
            sink_wait <= sink_wait - 1;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : store_check
        res_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                frame_byte(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                if (stores_due.size() == 0)
                begin
                    $error("unexpected output transfer, out_byte 0x%0h", m_tdata[7:0]);
                    mismatches++;
                end
                else
                begin
                    want = stores_due.pop_front();
                    check_field("out_byte", want.out_byte, m_tdata[7:0]);
                    check_field("out_addr", want.out_addr, m_tdata[20:8]);
                    check_field("write_index", want.write_index, m_tdata[33:21]);
                    check_field("irq_code", want.irq_code, m_tdata[41:34]);
                    check_field("sysex_errors", want.sysex_errors, m_tdata[49:42]);
                    check_field("msg_done", want.msg_done, m_tuser[0]);
                    check_field("irq_valid", want.irq_valid, m_tuser[1]);
                    check_field("last", want.last, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[midi_message_framer_core] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_RING_START)
        begin
            ring_start_r = val[ADDR_BITS-1:0];
        end
        else
        begin
            ring_end_r = val;
        end
    endtask

    // The sender holds off until every expected store has come out. The state
    // is looked at mid-cycle, once all edge updates have settled.
    task automatic drain();
        while (rx_pending.size() != 0 || s_tvalid || stores_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic push_data(input int count);
        for (int i = 0; i < count; i++)
        begin
            rx_pending.push_back(8'($urandom_range(0, 127)));
        end
    endtask

    task automatic push_message();
        int unsigned kind;
        logic [7:0]  status;
        int          len;
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            status = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
            rx_pending.push_back(status);
            push_data(status_length(status));
            if ($urandom_range(0, 9) < 4)
            begin
                repeat ($urandom_range(1, 3)) push_data(status_length(status));
            end
        end
        else if (kind < 60)
        begin
            status = 8'($urandom_range(8'hf1, 8'hff));
            if (status == SYSEX_END)
            begin
                status = 8'hf6;
            end
            rx_pending.push_back(status);
            push_data(status_length(status));
        end
        else if (kind < 78)
        begin
            rx_pending.push_back(SYSEX_START);
            if ($urandom_range(0, 1) == 1)
            begin
                rx_pending.push_back(SYSEX_LEAD);
            end
            len = ($urandom_range(0, 99) < 3) ? $urandom_range(130, 260)
                                               : $urandom_range(0, 12);
            push_data(len);
            if ($urandom_range(0, 9) < 8)
            begin
                rx_pending.push_back(SYSEX_END);
            end
            else
            begin
                rx_pending.push_back(8'($urandom_range(8'h80, 8'hff)));
            end
        end
        else if (kind < 90)
        begin
            rx_pending.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            rx_pending.push_back(8'($urandom_range(8'h80, 8'hef)));
            rx_pending.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin : stimulus
        int unsigned            phase;
        int unsigned            goal;
        int unsigned            queued;
        logic [ADDR_BITS-1:0]   start_val;
        logic [END_BITS-1:0]    end_val;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Dropped byte, running status, raw status inside a message,
        // song position, sysex with interrupt, broken sysex, lone status.
        rx_pending = '{8'h05, 8'h90, 8'h3c, 8'h7f, 8'h00, 8'h40, 8'hc5, 8'hff,
                       8'hf2, 8'h01, 8'h02, 8'h45, 8'hf0, 8'h7d, 8'h01, 8'h02,
                       8'h03, 8'h04, 8'hf7, 8'hf0, 8'h11, 8'h90, 8'hff};
        drain();
        goal  = framed_bytes + RANDOM_GOAL;
        phase = 0;
        do
        begin
            if (phase != 0)
            begin
                case (phase % 8)
                    1: begin start_val = 13'd100;  end_val = 14'd108;  end
                    2: begin start_val = 13'd0;    end_val = 14'd1;    end
                    3: begin start_val = 13'd8191; end_val = 14'd8192; end
                    4: begin start_val = 13'd8191; end_val = 14'd1;    end
                    5: begin start_val = 13'd0;    end_val = 14'd8192; end
                    6: begin start_val = 13'd5000; end_val = 14'd5003; end
                    default:
                    begin
                        start_val = 13'($urandom_range(0, 8191));
                        end_val   = 14'($urandom_range(1, 8192));
                    end
                endcase
                write_reg(CFG_RING_START, {1'b0, start_val});
                write_reg(CFG_RING_END, end_val);
            end
            quiet_phase = (phase % 3 == 2);
            queued = 0;
            while (queued < CHUNK_ITEMS)
            begin
                queued = queued - rx_pending.size();
                push_message();
                queued = queued + rx_pending.size();
            end
            drain();
            phase++;
        end
        while (framed_bytes < goal);

        repeat (20) @(posedge clk);
        if (mismatches == 0 && stores_due.size() == 0)
        begin
            $display("[midi_message_framer_core] OK");
        end
        else
        begin
            $display("[midi_message_framer_core] ERROR");
        end
        $finish;
    end

endmodule
